// ===== rtl/strongly_connected_components_macros.svh =====
// Assertion macros used by the checker of this block
`ifndef STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH
`define STRONGLY_CONNECTED_COMPONENTS_MACROS_SVH

// Clocked assertion, held off during reset
`define SCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scc assertion failed");

// Clocked assertion that also holds during reset
`define SCC_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("scc assertion failed");

`endif

// ===== rtl/scc_pkg.sv =====
`timescale 1ns / 1ps
package scc_pkg;

  localparam int MAX_NODES = 64;
  localparam int MAX_EDGES = 1024;
  localparam int NODE_W    = 7;
  localparam int COMP_W    = 6;
  localparam int NIDX_W    = $clog2(MAX_NODES);
  localparam int EADDR_W   = $clog2(MAX_EDGES);
  localparam int ECNT_W    = $clog2(MAX_EDGES + 1);
  localparam int FCNT_W    = $clog2(MAX_NODES + 1);
  localparam int STK_W     = NODE_W + ECNT_W;

  localparam logic       CMD_ADD = 1'b0;
  localparam logic       CMD_RUN = 1'b1;
  localparam logic [1:0] CFG_ADDR_NUM_NODES = 2'd0;
  localparam logic [NODE_W-1:0] NUM_NODES_RESET = NODE_W'(MAX_NODES);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P1_ROOT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_FINISH,
    ST_POP_LD,
    ST_P2_POP,
    ST_P2_CHK,
    ST_RUN_END
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic add_edge;
    logic run_init;
    logic pass2_init;
    logic root_inc;
    logic visit_root;
    logic scan_rd;
    logic scan_chk;
    logic finish;
    logic pop_ld;
    logic fin_rd;
    logic visit_fin;
    logic walk_end_rev;
    logic run_end;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic root_over;
    logic root_visited;
    logic scan_done;
    logic sp_one;
    logic reverse;
    logic fin_empty;
    logic fin_visited;
  } stat_t;

endpackage

// ===== rtl/strongly_connected_components.sv =====
`timescale 1ns / 1ps
// Channel   | Ports                                         | Handshake
// input     | in_cmd, in_from_node, in_to_node              | start high, busy low
// result    | out_node, out_component, out_component_end,   | out_valid, one cycle
//           | out_run_end, out_edges_dropped                |
// config    | psel, penable, pwrite, paddr, pwdata, prdata  | APB write, pready high
//
// An edge transaction leaves the block idle; start may be held to load one edge per cycle.
// In each pass of a run the single-port edge store is scanned once per node, each
// stored edge read and then checked against the node on top of the walk.
// Reset clears the edge count, drop flag and visited bits.
// Results come out one per cycle at most; the receiver cannot stall them.
module strongly_connected_components (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_cmd,
  input  logic [scc_pkg::NODE_W-1:0]  in_from_node,
  input  logic [scc_pkg::NODE_W-1:0]  in_to_node,
  output logic                        out_valid,
  output logic [scc_pkg::NODE_W-1:0]  out_node,
  output logic [scc_pkg::COMP_W-1:0]  out_component,
  output logic                        out_component_end,
  output logic                        out_run_end,
  output logic                        out_edges_dropped,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  scc_pkg::cmd_t  cmd;
  scc_pkg::stat_t stat;
  logic [scc_pkg::NODE_W-1:0] num_nodes_r;
  logic                       cfg_hit;

  assign cfg_hit = (paddr == scc_pkg::CFG_ADDR_NUM_NODES);

  // Node count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_nodes_r <= scc_pkg::NUM_NODES_RESET;
    end else if (psel && penable && pwrite && cfg_hit) begin
      num_nodes_r <= pwdata[scc_pkg::NODE_W-1:0];
    end
  end

  assign prdata = cfg_hit ? {{(32-scc_pkg::NODE_W){1'b0}}, num_nodes_r} : 32'd0;
  assign pready = 1'b1;

  scc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .in_cmd (in_cmd),
    .stat   (stat),
    .cmd    (cmd),
    .busy   (busy)
  );

  scc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .num_nodes         (num_nodes_r),
    .in_from_node      (in_from_node),
    .in_to_node        (in_to_node),
    .out_valid         (out_valid),
    .out_node          (out_node),
    .out_component     (out_component),
    .out_component_end (out_component_end),
    .out_run_end       (out_run_end),
    .out_edges_dropped (out_edges_dropped)
  );

endmodule

// ===== rtl/scc_ctrl.sv =====
`timescale 1ns / 1ps
module scc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_cmd,
  input  scc_pkg::stat_t  stat,
  output scc_pkg::cmd_t   cmd,
  output logic            busy
);

  scc_pkg::state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= scc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      scc_pkg::ST_IDLE: begin
        if (start) begin
          if (in_cmd == scc_pkg::CMD_RUN) begin
            cmd.run_init = 1'b1;
            state_nxt    = scc_pkg::ST_P1_ROOT;
          end else begin
            cmd.add_edge = 1'b1;
          end
        end
      end
      scc_pkg::ST_P1_ROOT: begin
        if (stat.root_over) begin
          cmd.pass2_init = 1'b1;
          state_nxt      = scc_pkg::ST_P2_POP;
        end else if (stat.root_visited) begin
          cmd.root_inc = 1'b1;
        end else begin
          cmd.visit_root = 1'b1;
          state_nxt      = scc_pkg::ST_SCAN_RD;
        end
      end
      scc_pkg::ST_SCAN_RD: begin
        if (stat.scan_done) begin
          state_nxt = scc_pkg::ST_FINISH;
        end else begin
          cmd.scan_rd = 1'b1;
          state_nxt   = scc_pkg::ST_SCAN_CHK;
        end
      end
      scc_pkg::ST_SCAN_CHK: begin
        cmd.scan_chk = 1'b1;
        state_nxt    = scc_pkg::ST_SCAN_RD;
      end
      scc_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        if (stat.sp_one) begin
          if (stat.reverse) begin
            cmd.walk_end_rev = 1'b1;
            state_nxt        = scc_pkg::ST_P2_POP;
          end else begin
            cmd.root_inc = 1'b1;
            state_nxt    = scc_pkg::ST_P1_ROOT;
          end
        end else begin
          state_nxt = scc_pkg::ST_POP_LD;
        end
      end
      scc_pkg::ST_POP_LD: begin
        cmd.pop_ld = 1'b1;
        state_nxt  = scc_pkg::ST_SCAN_RD;
      end
      scc_pkg::ST_P2_POP: begin
        if (stat.fin_empty) begin
          state_nxt = scc_pkg::ST_RUN_END;
        end else begin
          cmd.fin_rd = 1'b1;
          state_nxt  = scc_pkg::ST_P2_CHK;
        end
      end
      scc_pkg::ST_P2_CHK: begin
        if (stat.fin_visited) begin
          state_nxt = scc_pkg::ST_P2_POP;
        end else begin
          cmd.visit_fin = 1'b1;
          state_nxt     = scc_pkg::ST_SCAN_RD;
        end
      end
      scc_pkg::ST_RUN_END: begin
        cmd.run_end = 1'b1;
        state_nxt   = scc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = scc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != scc_pkg::ST_IDLE);

endmodule

// ===== rtl/scc_dp.sv =====
`timescale 1ns / 1ps
module scc_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  scc_pkg::cmd_t               cmd,
  output scc_pkg::stat_t              stat,
  input  logic [scc_pkg::NODE_W-1:0]  num_nodes,
  input  logic [scc_pkg::NODE_W-1:0]  in_from_node,
  input  logic [scc_pkg::NODE_W-1:0]  in_to_node,
  output logic                        out_valid,
  output logic [scc_pkg::NODE_W-1:0]  out_node,
  output logic [scc_pkg::COMP_W-1:0]  out_component,
  output logic                        out_component_end,
  output logic                        out_run_end,
  output logic                        out_edges_dropped
);

  localparam int NW = scc_pkg::NODE_W;
  localparam int EW = scc_pkg::ECNT_W;
  localparam int IW = scc_pkg::NIDX_W;

  // Memories
  logic [2*NW-1:0]             edge_mem [scc_pkg::MAX_EDGES];
  logic [scc_pkg::STK_W-1:0]   stk_mem  [scc_pkg::MAX_NODES];
  logic [NW-1:0]               fin_mem  [scc_pkg::MAX_NODES];

  logic [2*NW-1:0]             ed_q_r;
  logic [scc_pkg::STK_W-1:0]   stk_q_r;
  logic [NW-1:0]               fin_q_r;

  // Control registers
  logic [EW-1:0]                  edge_cnt_r;
  logic                           drop_r;
  logic [scc_pkg::MAX_NODES-1:0]  visited_r;
  logic [NW-1:0]                  top_u_r;
  logic [EW-1:0]                  top_i_r;
  logic [NW-1:0]                  sp_r;
  logic [scc_pkg::FCNT_W-1:0]     fin_len_r;
  logic [NW-1:0]                  root_r;
  logic                           reverse_r;
  logic [NW-1:0]                  comp_r;
  logic                           pend_v_r;
  logic [NW-1:0]                  pend_node_r;
  logic [scc_pkg::COMP_W-1:0]     pend_comp_r;
  logic                           pend_cend_r;
  logic                           out_valid_r;
  logic [NW-1:0]                  out_node_r;
  logic [scc_pkg::COMP_W-1:0]     out_comp_r;
  logic                           out_cend_r;
  logic                           out_rend_r;
  logic                           out_drop_r;

  logic [NW-1:0] n_eff;
  logic          add_ok;
  logic [NW-1:0] ea, eb;
  logic          hit;
  logic [NW-1:0] emit_node;
  logic          emit;

  // Saturate node count to 1..MAX_NODES
  always_comb begin
    if (num_nodes == '0) begin
      n_eff = NW'(1);
    end else if (num_nodes > NW'(scc_pkg::MAX_NODES)) begin
      n_eff = NW'(scc_pkg::MAX_NODES);
    end else begin
      n_eff = num_nodes;
    end
  end

  assign add_ok = (in_from_node != '0) && (in_from_node <= n_eff) &&
                  (in_to_node != '0) && (in_to_node <= n_eff) &&
                  (edge_cnt_r < EW'(scc_pkg::MAX_EDGES));

  // Edge ends as seen by the current pass
  assign ea  = reverse_r ? ed_q_r[NW-1:0] : ed_q_r[2*NW-1:NW];
  assign eb  = reverse_r ? ed_q_r[2*NW-1:NW] : ed_q_r[NW-1:0];
  assign hit = (ea == top_u_r) && (eb != '0) && (eb <= n_eff) &&
               !visited_r[IW'(eb - NW'(1))];

  assign emit      = cmd.visit_fin || (cmd.scan_chk && hit && reverse_r);
  assign emit_node = cmd.visit_fin ? fin_q_r : eb;

  // Status
  assign stat.root_over    = (root_r > n_eff);
  assign stat.root_visited = visited_r[IW'(root_r - NW'(1))];
  assign stat.scan_done    = (top_i_r >= edge_cnt_r);
  assign stat.sp_one       = (sp_r == NW'(1));
  assign stat.reverse      = reverse_r;
  assign stat.fin_empty    = (fin_len_r == '0);
  assign stat.fin_visited  = visited_r[IW'(fin_q_r - NW'(1))];

  // Edge store
  always_ff @(posedge clk) begin
    if (cmd.add_edge && add_ok) begin
      edge_mem[edge_cnt_r[scc_pkg::EADDR_W-1:0]] <= {in_from_node, in_to_node};
    end
    if (cmd.scan_rd) begin
      ed_q_r <= edge_mem[top_i_r[scc_pkg::EADDR_W-1:0]];
    end
  end

  // Walk stack below the top entry
  always_ff @(posedge clk) begin
    if (cmd.scan_chk && hit) begin
      stk_mem[IW'(sp_r - NW'(1))] <= {top_u_r, top_i_r + EW'(1)};
    end
    if (cmd.finish) begin
      stk_q_r <= stk_mem[IW'(sp_r - NW'(2))];
    end
  end

  // Finish order
  always_ff @(posedge clk) begin
    if (cmd.finish && !reverse_r) begin
      fin_mem[fin_len_r[IW-1:0]] <= top_u_r;
    end
    if (cmd.fin_rd) begin
      fin_q_r <= fin_mem[IW'(fin_len_r - scc_pkg::FCNT_W'(1))];
    end
  end

  // Walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edge_cnt_r <= '0;
      drop_r     <= 1'b0;
      visited_r  <= '0;
      sp_r       <= '0;
      fin_len_r  <= '0;
      root_r     <= NW'(1);
      reverse_r  <= 1'b0;
      comp_r     <= '0;
      pend_v_r   <= 1'b0;
      top_u_r    <= '0;
      top_i_r    <= '0;
    end else begin
      if (cmd.add_edge) begin
        if (add_ok) begin
          edge_cnt_r <= edge_cnt_r + EW'(1);
        end else begin
          drop_r <= 1'b1;
        end
      end
      if (cmd.run_init) begin
        visited_r <= '0;
        fin_len_r <= '0;
        root_r    <= NW'(1);
        reverse_r <= 1'b0;
        comp_r    <= '0;
        pend_v_r  <= 1'b0;
      end
      if (cmd.pass2_init) begin
        visited_r <= '0;
        reverse_r <= 1'b1;
      end
      if (cmd.root_inc) begin
        root_r <= root_r + NW'(1);
      end
      if (cmd.visit_root) begin
        visited_r[IW'(root_r - NW'(1))] <= 1'b1;
        top_u_r <= root_r;
        top_i_r <= '0;
        sp_r    <= NW'(1);
      end
      if (cmd.visit_fin) begin
        visited_r[IW'(fin_q_r - NW'(1))] <= 1'b1;
        top_u_r <= fin_q_r;
        top_i_r <= '0;
        sp_r    <= NW'(1);
      end
      // Advance the scan; push on a new neighbor
      if (cmd.scan_chk) begin
        if (hit) begin
          visited_r[IW'(eb - NW'(1))] <= 1'b1;
          top_u_r <= eb;
          top_i_r <= '0;
          sp_r    <= sp_r + NW'(1);
        end else begin
          top_i_r <= top_i_r + EW'(1);
        end
      end
      if (cmd.finish) begin
        sp_r <= sp_r - NW'(1);
        if (!reverse_r) begin
          fin_len_r <= fin_len_r + scc_pkg::FCNT_W'(1);
        end
      end
      if (cmd.pop_ld) begin
        top_u_r <= stk_q_r[scc_pkg::STK_W-1:EW];
        top_i_r <= stk_q_r[EW-1:0];
      end
      if (cmd.fin_rd) begin
        fin_len_r <= fin_len_r - scc_pkg::FCNT_W'(1);
      end
      if (cmd.walk_end_rev) begin
        comp_r <= comp_r + NW'(1);
      end
      if (emit) begin
        pend_v_r <= 1'b1;
      end
      if (cmd.run_end) begin
        edge_cnt_r <= '0;
        drop_r     <= 1'b0;
        pend_v_r   <= 1'b0;
      end
    end
  end

  // Hold one visited node back until its successor or the run end is known
  always_ff @(posedge clk) begin
    if (emit) begin
      pend_node_r <= emit_node;
      pend_comp_r <= comp_r[scc_pkg::COMP_W-1:0];
      pend_cend_r <= 1'b0;
    end else if (cmd.walk_end_rev) begin
      pend_cend_r <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (emit && pend_v_r) || (cmd.run_end && pend_v_r);
    end
  end

  always_ff @(posedge clk) begin
    if (emit || cmd.run_end) begin
      out_node_r <= pend_node_r;
      out_comp_r <= pend_comp_r;
      out_cend_r <= pend_cend_r || cmd.run_end;
      out_rend_r <= cmd.run_end;
      out_drop_r <= drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_node          = out_node_r;
  assign out_component     = out_comp_r;
  assign out_component_end = out_cend_r;
  assign out_run_end       = out_rend_r;
  assign out_edges_dropped = out_drop_r;

endmodule

// ===== rtl/scc_checker.sv =====
`timescale 1ns / 1ps
`include "strongly_connected_components_macros.svh"
module scc_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        start,
  input logic                        busy,
  input logic                        in_cmd,
  input logic                        out_valid,
  input logic                        out_component_end,
  input logic                        out_run_end,
  input logic                        pready
);

  // A run transaction makes the block busy
  `SCC_ASSERT(a_run_busy, (start && !busy && in_cmd) |=> busy)
  // An edge transaction leaves the block free
  `SCC_ASSERT(a_add_free, (start && !busy && !in_cmd) |=> !busy)
  // The last result of a run also closes its component
  `SCC_ASSERT(a_end_comp, (out_valid && out_run_end) |-> out_component_end)
  // Nothing follows the last result of a run
  `SCC_ASSERT(a_end_quiet, (out_valid && out_run_end) |=> !out_valid)
  // The port is always ready
  `SCC_ASSERT_ALWAYS(a_ready, pready)

endmodule

bind strongly_connected_components scc_checker u_scc_checker (.*);
